FILE: hw/rtl/efl_pkg.sv
// efl_pkg: shared types and constants of the exact-fit free-list allocator.
// Used by efl_ctrl, efl_dpath, the top level and the checker.
package efl_pkg;

    localparam int FREE_ENTRIES_DEF = 64;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int ADDR_BITS_DEF    = 48;

    localparam int DATA_W    = 48;
    localparam int SIZE_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int WIDE_W    = 64;

    localparam logic [WIDE_W-1:0] BUMP_ROUND = 64'd15;
    localparam logic [WIDE_W-1:0] BUMP_MASK  = ~64'h0f;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_REUSED     = 2'd0,
        ST_FRESH      = 2'd1,
        ST_CHIP_OOM   = 2'd2,
        ST_TABLE_FULL = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_BASE   = 2'd0,
        CFG_CHIP_BASE   = 2'd1,
        CFG_CHIP_LIMIT  = 2'd2,
        CFG_TOTAL_BYTES = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              chip;
        logic [SIZE_W-1:0] size;
        logic [DATA_W-1:0] addr;
    } t_entry;

    typedef struct packed {
        logic    latch;
        logic    push;
        logic    scan_init;
        logic    scan_run;
        logic    take;
        logic    shift_run;
        logic    pop;
        logic    bump;
        logic    emit;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic full;
        logic empty;
        logic hit;
        logic miss;
        logic shift_done;
        logic bump_fail;
    } t_dp_sts;

endpackage

FILE: hw/rtl/exact_fit_free_list_allocator_top.sv
// exact_fit_free_list_allocator_top: allocator top level, joins efl_ctrl
// and efl_dpath. Depends on efl_pkg.
//
// Usage: raise start with a request on the i_ field ports; it is taken at
// a rising edge with start high and busy low. busy stays high until the
// reply is formed. One reply per request appears on o_status,
// o_payload_address, o_used_bytes and o_avail_bytes for exactly one cycle
// with o_valid high; the receiver cannot stall it.
// Config registers (data_base, chip_base, chip_limit, total_bytes) are
// written through i_cfg_we/i_cfg_idx/i_cfg_wdata; the user must write
// them only while busy is low, which the block itself does not enforce.
// A free and an allocate on an empty table need no scan. An allocate
// scans the free table newest first, one entry per cycle through the
// table memory's single read port; a miss over all entries falls back to
// the bump, and on a hit the entries above the hit are then moved down one
// per cycle. Requests do not overlap. Reset (synchronous, active low)
// empties the table, clears the used count, zeroes the config registers
// and re-arms both breaks to load their base at their first bump.
module exact_fit_free_list_allocator_top #(
    parameter int FREE_ENTRIES = efl_pkg::FREE_ENTRIES_DEF,
    parameter int HEADER_BYTES = efl_pkg::HEADER_BYTES_DEF,
    parameter int ADDR_BITS    = efl_pkg::ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [efl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [efl_pkg::DATA_W-1:0]    i_cfg_wdata,
    input  logic                          i_command,
    input  logic [efl_pkg::SIZE_W-1:0]    i_req_size,
    input  logic                          i_chip_region,
    input  logic [efl_pkg::DATA_W-1:0]    i_block_address,
    input  logic [efl_pkg::SIZE_W-1:0]    i_freed_size,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [efl_pkg::DATA_W-1:0]    o_payload_address,
    output logic [efl_pkg::DATA_W-1:0]    o_used_bytes,
    output logic [efl_pkg::DATA_W-1:0]    o_avail_bytes
);
    import efl_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    efl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    efl_dpath #(
        .FREE_ENTRIES (FREE_ENTRIES),
        .HEADER_BYTES (HEADER_BYTES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_command         (i_command),
        .i_req_size        (i_req_size),
        .i_chip_region     (i_chip_region),
        .i_block_address   (i_block_address),
        .i_freed_size      (i_freed_size),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_payload_address (o_payload_address),
        .o_used_bytes      (o_used_bytes),
        .o_avail_bytes     (o_avail_bytes)
    );

endmodule

FILE: hw/rtl/efl_ctrl.sv
// efl_ctrl: request sequencer of the allocator (dispatch, table scan,
// compaction, bump, reply). Depends on efl_pkg.
module efl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  efl_pkg::t_dp_sts i_sts,
    output efl_pkg::t_dp_cmd o_cmd
);
    import efl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_BUMP,
        S_CHECK,
        S_REPLY
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.is_free) begin
                    o_cmd.push = 1'b1;
                    n_status   = i_sts.full ? ST_TABLE_FULL : ST_REUSED;
                    n_state    = S_REPLY;
                end else if (i_sts.empty) begin
                    n_state = S_BUMP;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.take = 1'b1;
                    n_status   = ST_REUSED;
                    n_state    = S_SHIFT;
                end else if (i_sts.miss) begin
                    n_state = S_BUMP;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_run = 1'b1;
                if (i_sts.shift_done) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_REPLY;
                end
            end
            S_BUMP: begin
                o_cmd.bump = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                n_status = i_sts.bump_fail ? ST_CHIP_OOM : ST_FRESH;
                n_state  = S_REPLY;
            end
            S_REPLY: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_REUSED;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

FILE: hw/rtl/efl_dpath.sv
// efl_dpath: config registers, free-entry memory, region breaks, used count
// and the registered result port. Depends on efl_pkg.
module efl_dpath #(
    parameter int FREE_ENTRIES = efl_pkg::FREE_ENTRIES_DEF,
    parameter int HEADER_BYTES = efl_pkg::HEADER_BYTES_DEF,
    parameter int ADDR_BITS    = efl_pkg::ADDR_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [efl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [efl_pkg::DATA_W-1:0]     i_cfg_wdata,
    input  logic                           i_command,
    input  logic [efl_pkg::SIZE_W-1:0]     i_req_size,
    input  logic                           i_chip_region,
    input  logic [efl_pkg::DATA_W-1:0]     i_block_address,
    input  logic [efl_pkg::SIZE_W-1:0]     i_freed_size,
    input  efl_pkg::t_dp_cmd               i_cmd,
    output efl_pkg::t_dp_sts               o_sts,
    output logic                           o_valid,
    output logic [1:0]                     o_status,
    output logic [efl_pkg::DATA_W-1:0]     o_payload_address,
    output logic [efl_pkg::DATA_W-1:0]     o_used_bytes,
    output logic [efl_pkg::DATA_W-1:0]     o_avail_bytes
);
    import efl_pkg::*;

    localparam int IDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(FREE_ENTRIES + 1);

    // configuration
    logic [DATA_W-1:0] r_data_base, r_chip_base, r_chip_limit, r_total;

    // latched request
    logic              r_is_free;
    logic [SIZE_W-1:0] r_req_size;
    logic              r_req_chip;
    logic [DATA_W-1:0] r_blk_addr;
    logic [SIZE_W-1:0] r_fsize;

    // free table
    t_entry            mem [FREE_ENTRIES];
    t_entry            r_rdata;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_ptr, r_rd_idx, r_wr_idx;
    logic              r_issue, r_rd_vld, r_rd_last, r_wr_pend;

    // breaks and counters
    logic [ADDR_BITS-1:0] r_data_brk, r_chip_brk, r_blk;
    logic                 r_data_started, r_chip_started, r_pre_fail;
    logic [DATA_W-1:0]    r_used, r_hit_addr;

    // result
    logic              r_valid;
    t_status           r_status;
    logic [DATA_W-1:0] r_pay, r_used_o, r_avail;

    logic                 full, empty, match, sh_more, pre_fail, bump_fail;
    logic [CNT_W-1:0]     sh_next;
    logic [IDX_W-1:0]     rd_addr, wr_addr;
    logic                 wr_en;
    t_entry               wr_data, push_data;
    logic [WIDE_W-1:0]    inc64, eff64, new64, limit64, chip_base64, data_base64;
    logic [WIDE_W-1:0]    chip_brk64, blk_hdr64;
    logic [ADDR_BITS-1:0] eff_brk, new_brk, blk_hdr;

    assign full    = (r_count == CNT_W'(FREE_ENTRIES));
    assign empty   = (r_count == '0);
    assign match   = (r_rdata.size == r_req_size) && (r_rdata.chip == r_req_chip);
    assign sh_next = CNT_W'(r_ptr) + CNT_W'(1);
    assign sh_more = (sh_next < r_count);
    assign rd_addr = i_cmd.shift_run ? IDX_W'(sh_next) : r_ptr;

    assign push_data.chip = r_req_chip;
    assign push_data.size = r_fsize;
    assign push_data.addr = r_blk_addr;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wr_idx;
        wr_data = r_rdata;
        if (i_cmd.push && !full) begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(r_count);
            wr_data = push_data;
        end else if (i_cmd.shift_run && r_wr_pend) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // bump arithmetic
    assign inc64       = (WIDE_W'(HEADER_BYTES) + WIDE_W'(r_req_size) + BUMP_ROUND) & BUMP_MASK;
    assign chip_base64 = WIDE_W'(r_chip_base);
    assign data_base64 = WIDE_W'(r_data_base);
    always_comb begin
        if (r_req_chip) begin
            eff_brk = r_chip_started ? r_chip_brk : chip_base64[ADDR_BITS-1:0];
        end else begin
            eff_brk = r_data_started ? r_data_brk : data_base64[ADDR_BITS-1:0];
        end
    end
    assign eff64      = WIDE_W'(eff_brk);
    assign new64      = eff64 + inc64;
    assign new_brk    = new64[ADDR_BITS-1:0];
    assign limit64    = WIDE_W'(r_chip_limit);
    assign pre_fail   = (eff64 > limit64);
    assign chip_brk64 = WIDE_W'(r_chip_brk);
    assign bump_fail  = r_req_chip && (r_pre_fail || (chip_brk64 > limit64));
    assign blk_hdr    = r_blk + ADDR_BITS'(HEADER_BYTES);
    assign blk_hdr64  = WIDE_W'(blk_hdr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_base  <= '0;
            r_chip_base  <= '0;
            r_chip_limit <= '0;
            r_total      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DATA_BASE:   r_data_base  <= i_cfg_wdata;
                CFG_CHIP_BASE:   r_chip_base  <= i_cfg_wdata;
                CFG_CHIP_LIMIT:  r_chip_limit <= i_cfg_wdata;
                CFG_TOTAL_BYTES: r_total      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_used         <= '0;
            r_data_started <= 1'b0;
            r_chip_started <= 1'b0;
            r_issue        <= 1'b0;
            r_rd_vld       <= 1'b0;
            r_wr_pend      <= 1'b0;
            r_valid        <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.push && !full) begin
                r_count <= r_count + CNT_W'(1);
                if (!r_req_chip) begin
                    r_used <= r_used - DATA_W'(r_fsize);
                end
            end
            if (i_cmd.pop) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.scan_init) begin
                r_issue  <= 1'b1;
                r_rd_vld <= 1'b0;
            end
            if (i_cmd.scan_run) begin
                r_rd_vld <= r_issue;
                if (r_issue && (r_ptr == '0)) begin
                    r_issue <= 1'b0;
                end
            end
            if (i_cmd.take) begin
                r_wr_pend <= 1'b0;
                if (!r_req_chip) begin
                    r_used <= r_used + DATA_W'(r_req_size);
                end
            end
            if (i_cmd.shift_run) begin
                r_wr_pend <= sh_more;
            end
            if (i_cmd.bump) begin
                if (r_req_chip) begin
                    r_chip_started <= 1'b1;
                end else begin
                    r_data_started <= 1'b1;
                    r_used         <= r_used + DATA_W'(r_req_size);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_is_free  <= (i_command == CMD_FREE);
            r_req_size <= i_req_size;
            r_req_chip <= i_chip_region;
            r_blk_addr <= i_block_address;
            r_fsize    <= i_freed_size;
            r_hit_addr <= '0;
        end
        if (i_cmd.scan_init) begin
            r_ptr <= IDX_W'(r_count - CNT_W'(1));
        end
        if (i_cmd.scan_run) begin
            r_rd_idx  <= r_ptr;
            r_rd_last <= (r_ptr == '0);
            if (r_issue && (r_ptr != '0) && !i_cmd.take) begin
                r_ptr <= r_ptr - IDX_W'(1);
            end
        end
        if (i_cmd.take) begin
            r_ptr      <= r_rd_idx;
            r_hit_addr <= r_rdata.addr;
        end else if (i_cmd.shift_run && sh_more) begin
            r_wr_idx <= r_ptr;
            r_ptr    <= IDX_W'(sh_next);
        end
        if (i_cmd.bump) begin
            r_blk <= eff_brk;
            if (r_req_chip) begin
                r_pre_fail <= pre_fail;
                r_chip_brk <= pre_fail ? eff_brk : new_brk;
            end else begin
                r_pre_fail <= 1'b0;
                r_data_brk <= new_brk;
            end
        end
        if (i_cmd.emit) begin
            r_status <= i_cmd.status;
            case (i_cmd.status)
                ST_REUSED: r_pay <= r_hit_addr;
                ST_FRESH:  r_pay <= blk_hdr64[DATA_W-1:0];
                default:   r_pay <= '0;
            endcase
            r_used_o <= r_used;
            r_avail  <= (r_total > r_used) ? (r_total - r_used) : '0;
        end
    end

    assign o_sts.is_free    = r_is_free;
    assign o_sts.full       = full;
    assign o_sts.empty      = empty;
    assign o_sts.hit        = r_rd_vld && match;
    assign o_sts.miss       = r_rd_vld && !match && r_rd_last;
    assign o_sts.shift_done = !sh_more && !r_wr_pend;
    assign o_sts.bump_fail  = bump_fail;

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_payload_address = r_pay;
    assign o_used_bytes      = r_used_o;
    assign o_avail_bytes     = r_avail;

endmodule

FILE: hw/rtl/efl_checker.sv
// efl_checker: port-level assertions for the allocator top level, plus the
// bind that attaches them. Depends on efl_pkg.
module efl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [1:0]                    o_status,
    input logic [efl_pkg::DATA_W-1:0]    o_payload_address
);
    import efl_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_done_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("request finished without a reply");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_CHIP_OOM || o_status == ST_TABLE_FULL)
        |-> o_payload_address == '0)
        else $error("failed request returned a nonzero address");

endmodule

bind exact_fit_free_list_allocator_top efl_checker u_efl_checker (.*);
